FILE: hw/rtl/wsne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsne_pkg
// Types, constants, fixed-point helpers and the microprogram of the stereo
// SE(3) normal-equation accumulator.
// ----------------------------------------------------------------------------
package wsne_pkg;

  localparam int ACC_WIDTH       = 64;
  localparam int COORD_FRAC_BITS = 16;
  localparam int QF              = 32;

  localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ACC_MAX = 64'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);
  localparam logic [63:0] ACC_MIN = ~ACC_MAX;

  localparam logic [2:0] CFG_BASELINE = 3'd7;
  localparam logic [5:0] LAST_ENTRY   = 6'd41;
  localparam logic [4:0] LAST_ACC     = 5'd26;

  // register file map
  localparam int RF_N0  = 0;
  localparam int RF_G0  = 21;
  localparam int RF_M0  = 27;
  localparam int RF_D1  = 35;
  localparam int RF_D2  = 36;
  localparam int RF_XR  = 37;
  localparam int RF_YR  = 38;
  localparam int RF_ZR  = 39;
  localparam int RF_INV = 40;
  localparam int RF_T2  = 41;
  localparam int RF_T6  = 42;
  localparam int RF_T3  = 43;
  localparam int RF_T4  = 44;
  localparam int RF_T5  = 45;
  localparam int RF_TW  = 46;
  localparam int RF_L1  = 47;
  localparam int RF_L2  = 53;
  localparam int RF_TA  = 59;
  localparam int RF_TB  = 60;

  // operand sources outside the register file
  localparam int SRC_BASE = 64;
  localparam int SRC_ZERO = 64;
  localparam int SRC_ONE  = 65;
  localparam int SRC_R00  = 66;
  localparam int SRC_R01  = 67;
  localparam int SRC_R02  = 68;
  localparam int SRC_R10  = 69;
  localparam int SRC_R11  = 70;
  localparam int SRC_R12  = 71;
  localparam int SRC_R20  = 72;
  localparam int SRC_R21  = 73;
  localparam int SRC_R22  = 74;
  localparam int SRC_TX   = 75;
  localparam int SRC_TY   = 76;
  localparam int SRC_TZ   = 77;
  localparam int SRC_DX   = 78;
  localparam int SRC_FU   = 79;
  localparam int SRC_FV   = 80;
  localparam int SRC_CU   = 81;
  localparam int SRC_CV   = 82;
  localparam int SRC_X    = 83;
  localparam int SRC_Y    = 84;
  localparam int SRC_Z    = 85;
  localparam int SRC_W    = 86;
  localparam int SRC_DU   = 87;
  localparam int SRC_DV   = 88;
  localparam int SRC_NUM  = 25;

  localparam logic [7:0] PC_COEF  = 8'd0;
  localparam logic [7:0] PC_POINT = 8'd32;

  typedef enum logic [2:0] {
    OP_END, OP_MUL, OP_ADD, OP_SUB, OP_ADDA, OP_SUBA, OP_DIV, OP_TEST
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] dst;
    logic [6:0] a;
    logic [6:0] b;
  } instr_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_WAIT, S_EREAD, S_ELOAD
  } ctrl_state_t;

  typedef struct packed {
    instr_t     instr;
    logic       rd;
    logic [6:0] rd_a;
    logic [6:0] rd_b;
    logic       go;
    logic       wb;
    logic       skip_inc;
    logic       oload;
    logic [5:0] oidx;
    logic       clr;
    logic [4:0] clr_addr;
    logic       load_in;
  } dp_cmd_t;

  typedef struct packed {
    logic nonpos;
    logic unit_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] from_mag(logic neg, logic [63:0] r, logic ovf);
    if (neg) begin
      return (ovf || r[63]) ? S64_MIN : (64'd0 - r);
    end
    return (ovf || r[63]) ? S64_MAX : r;
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] acc_sat(logic [63:0] v);
    if ($signed(v) > $signed(ACC_MAX)) return ACC_MAX;
    if ($signed(v) < $signed(ACC_MIN)) return ACC_MIN;
    return v;
  endfunction

  function automatic logic [63:0] coord_q(logic [31:0] v);
    logic [63:0] t;
    t = {{32{v[31]}}, v};
    return t << (QF - COORD_FRAC_BITS);
  endfunction

  function automatic logic [63:0] rot_q(logic [31:0] v);
    logic [63:0] t;
    t = {{32{v[31]}}, v};
    return t << 2;
  endfunction

  function automatic logic [63:0] weight_q(logic [31:0] v);
    logic [63:0] t;
    t = {32'd0, v};
    return t << (QF - COORD_FRAC_BITS);
  endfunction

  function automatic logic [63:0] intr_q(logic [15:0] v);
    return {20'd0, v, 28'd0};
  endfunction

  function automatic instr_t mk(op_t op, int dst, int a, int b);
    instr_t i;
    i.op  = op;
    i.dst = 6'(dst);
    i.a   = 7'(a);
    i.b   = 7'(b);
    return i;
  endfunction

  function automatic int tri_idx(int k, int l);
    return k * (k + 1) / 2 + l;
  endfunction

  // register file address of emitted entry k
  function automatic logic [5:0] entry_addr(logic [5:0] k);
    logic [5:0] res;
    int hi;
    int lo;
    res = 6'(RF_G0);
    for (int r = 0; r < 6; r++) begin
      for (int c = 0; c < 6; c++) begin
        hi = (r > c) ? r : c;
        lo = (r > c) ? c : r;
        if (k == 6'(r * 6 + c)) res = 6'(tri_idx(hi, lo));
      end
    end
    for (int g = 0; g < 6; g++) begin
      if (k == 6'(36 + g)) res = 6'(RF_G0 + g);
    end
    return res;
  endfunction

  function automatic instr_t prog(logic [7:0] pc);
    instr_t ins;
    int p;
    int o;
    int t;
    int ma;
    int lb;
    int blk;
    int s;
    int kk;
    int ll;
    int idx;
    p   = int'(pc);
    ins = mk(OP_END, 0, 0, 0);
    kk  = 0;
    ll  = 0;
    if (p <= 26) begin
      case (p)
        0:  ins = mk(OP_MUL, RF_TA, SRC_FU, SRC_R00);
        1:  ins = mk(OP_MUL, RF_TB, SRC_CU, SRC_R20);
        2:  ins = mk(OP_ADD, RF_M0 + 0, RF_TA, RF_TB);
        3:  ins = mk(OP_MUL, RF_TA, SRC_FU, SRC_R01);
        4:  ins = mk(OP_MUL, RF_TB, SRC_CU, SRC_R21);
        5:  ins = mk(OP_ADD, RF_M0 + 1, RF_TA, RF_TB);
        6:  ins = mk(OP_MUL, RF_TA, SRC_FU, SRC_R02);
        7:  ins = mk(OP_MUL, RF_TB, SRC_CU, SRC_R22);
        8:  ins = mk(OP_ADD, RF_M0 + 2, RF_TA, RF_TB);
        9:  ins = mk(OP_MUL, RF_TA, SRC_FU, SRC_TX);
        10: ins = mk(OP_MUL, RF_TB, SRC_FU, SRC_DX);
        11: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        12: ins = mk(OP_MUL, RF_TB, SRC_CU, SRC_TZ);
        13: ins = mk(OP_ADD, RF_M0 + 3, RF_TA, RF_TB);
        14: ins = mk(OP_MUL, RF_TA, SRC_FV, SRC_R10);
        15: ins = mk(OP_MUL, RF_TB, SRC_CV, SRC_R20);
        16: ins = mk(OP_ADD, RF_M0 + 4, RF_TA, RF_TB);
        17: ins = mk(OP_MUL, RF_TA, SRC_FV, SRC_R11);
        18: ins = mk(OP_MUL, RF_TB, SRC_CV, SRC_R21);
        19: ins = mk(OP_ADD, RF_M0 + 5, RF_TA, RF_TB);
        20: ins = mk(OP_MUL, RF_TA, SRC_FV, SRC_R12);
        21: ins = mk(OP_MUL, RF_TB, SRC_CV, SRC_R22);
        22: ins = mk(OP_ADD, RF_M0 + 6, RF_TA, RF_TB);
        23: ins = mk(OP_MUL, RF_TA, SRC_FV, SRC_TY);
        24: ins = mk(OP_MUL, RF_TB, SRC_CV, SRC_TZ);
        25: ins = mk(OP_ADD, RF_M0 + 7, RF_TA, RF_TB);
        default: ins = mk(OP_END, 0, 0, 0);
      endcase
    end else if (p >= 32 && p <= 65) begin
      case (p)
        32: ins = mk(OP_MUL, RF_D1, SRC_W, SRC_DU);
        33: ins = mk(OP_MUL, RF_D2, SRC_W, SRC_DV);
        34: ins = mk(OP_MUL, RF_TA, RF_M0 + 0, SRC_X);
        35: ins = mk(OP_MUL, RF_TB, RF_M0 + 1, SRC_Y);
        36: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        37: ins = mk(OP_MUL, RF_TB, RF_M0 + 2, SRC_Z);
        38: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        39: ins = mk(OP_ADD, RF_XR, RF_TA, RF_M0 + 3);
        40: ins = mk(OP_MUL, RF_TA, RF_M0 + 4, SRC_X);
        41: ins = mk(OP_MUL, RF_TB, RF_M0 + 5, SRC_Y);
        42: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        43: ins = mk(OP_MUL, RF_TB, RF_M0 + 6, SRC_Z);
        44: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        45: ins = mk(OP_ADD, RF_YR, RF_TA, RF_M0 + 7);
        46: ins = mk(OP_MUL, RF_TA, SRC_R20, SRC_X);
        47: ins = mk(OP_MUL, RF_TB, SRC_R21, SRC_Y);
        48: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        49: ins = mk(OP_MUL, RF_TB, SRC_R22, SRC_Z);
        50: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        51: ins = mk(OP_ADD, RF_ZR, RF_TA, SRC_TZ);
        52: ins = mk(OP_TEST, 0, RF_ZR, SRC_ZERO);
        53: ins = mk(OP_DIV, RF_INV, SRC_ONE, RF_ZR);
        54: ins = mk(OP_MUL, RF_T2, RF_INV, RF_XR);
        55: ins = mk(OP_MUL, RF_T6, RF_INV, RF_YR);
        56: ins = mk(OP_MUL, RF_TA, SRC_R21, SRC_Z);
        57: ins = mk(OP_MUL, RF_TB, SRC_R22, SRC_Y);
        58: ins = mk(OP_SUB, RF_T3, RF_TA, RF_TB);
        59: ins = mk(OP_MUL, RF_TA, SRC_R22, SRC_X);
        60: ins = mk(OP_MUL, RF_TB, SRC_R20, SRC_Z);
        61: ins = mk(OP_SUB, RF_T4, RF_TA, RF_TB);
        62: ins = mk(OP_MUL, RF_TA, SRC_R20, SRC_Y);
        63: ins = mk(OP_MUL, RF_TB, SRC_R21, SRC_X);
        64: ins = mk(OP_SUB, RF_T5, RF_TA, RF_TB);
        65: ins = mk(OP_DIV, RF_TW, SRC_W, RF_ZR);
        default: ins = mk(OP_END, 0, 0, 0);
      endcase
    end else if (p >= 66 && p <= 119) begin
      // interaction rows: first row from t2 and m0..m2, second from t6 and m4..m6
      o  = (p >= 93) ? p - 93 : p - 66;
      t  = (p >= 93) ? RF_T6 : RF_T2;
      ma = (p >= 93) ? RF_M0 + 4 : RF_M0;
      lb = (p >= 93) ? RF_L2 : RF_L1;
      case (o)
        0:  ins = mk(OP_MUL, RF_TA, t, SRC_R20);
        1:  ins = mk(OP_SUB, RF_TA, ma, RF_TA);
        2:  ins = mk(OP_MUL, lb + 0, RF_TW, RF_TA);
        3:  ins = mk(OP_MUL, RF_TA, t, SRC_R21);
        4:  ins = mk(OP_SUB, RF_TA, ma + 1, RF_TA);
        5:  ins = mk(OP_MUL, lb + 1, RF_TW, RF_TA);
        6:  ins = mk(OP_MUL, RF_TA, t, SRC_R22);
        7:  ins = mk(OP_SUB, RF_TA, ma + 2, RF_TA);
        8:  ins = mk(OP_MUL, lb + 2, RF_TW, RF_TA);
        9:  ins = mk(OP_MUL, RF_TA, t, RF_T3);
        10: ins = mk(OP_MUL, RF_TB, ma + 2, SRC_Y);
        11: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        12: ins = mk(OP_MUL, RF_TB, ma + 1, SRC_Z);
        13: ins = mk(OP_SUB, RF_TA, RF_TA, RF_TB);
        14: ins = mk(OP_MUL, lb + 3, RF_TW, RF_TA);
        15: ins = mk(OP_MUL, RF_TA, t, RF_T4);
        16: ins = mk(OP_MUL, RF_TB, ma + 2, SRC_X);
        17: ins = mk(OP_SUB, RF_TA, RF_TA, RF_TB);
        18: ins = mk(OP_MUL, RF_TB, ma, SRC_Z);
        19: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        20: ins = mk(OP_MUL, lb + 4, RF_TW, RF_TA);
        21: ins = mk(OP_MUL, RF_TA, t, RF_T5);
        22: ins = mk(OP_MUL, RF_TB, ma + 1, SRC_X);
        23: ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        24: ins = mk(OP_MUL, RF_TB, ma, SRC_Y);
        25: ins = mk(OP_SUB, RF_TA, RF_TA, RF_TB);
        26: ins = mk(OP_MUL, lb + 5, RF_TW, RF_TA);
        default: ins = mk(OP_END, 0, 0, 0);
      endcase
    end else if (p >= 120 && p <= 203) begin
      blk = (p - 120) / 4;
      s   = (p - 120) % 4;
      for (int k = 0; k < 6; k++) begin
        for (int l = 0; l <= k; l++) begin
          if (blk == tri_idx(k, l)) begin
            kk = k;
            ll = l;
          end
        end
      end
      idx = RF_N0 + tri_idx(kk, ll);
      case (s)
        0:       ins = mk(OP_MUL, RF_TA, RF_L1 + kk, RF_L1 + ll);
        1:       ins = mk(OP_MUL, RF_TB, RF_L2 + kk, RF_L2 + ll);
        2:       ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        default: ins = mk(OP_ADDA, idx, idx, RF_TA);
      endcase
    end else if (p >= 204 && p <= 227) begin
      kk = (p - 204) / 4;
      s  = (p - 204) % 4;
      case (s)
        0:       ins = mk(OP_MUL, RF_TA, RF_L1 + kk, RF_D1);
        1:       ins = mk(OP_MUL, RF_TB, RF_L2 + kk, RF_D2);
        2:       ins = mk(OP_ADD, RF_TA, RF_TA, RF_TB);
        default: ins = mk(OP_SUBA, RF_G0 + kk, RF_G0 + kk, RF_TA);
      endcase
    end
    return ins;
  endfunction

endpackage

FILE: hw/rtl/wsne_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsne_mul
// Q32.32 multiplier, rounded half away from zero and saturated; four 32x32
// partial products over successive cycles.
// ----------------------------------------------------------------------------
module wsne_mul
  import wsne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic         busy;
  logic [2:0]   step;
  logic         neg;
  logic [63:0]  xm;
  logic [63:0]  ym;
  logic [63:0]  pp;
  logic [127:0] prod;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [127:0] pp_sh;

  always_comb begin
    xs = (step == 3'd2 || step == 3'd3) ? xm[63:32] : xm[31:0];
    ys = (step == 3'd1 || step == 3'd3) ? ym[63:32] : ym[31:0];
    case (step)
      3'd1:       pp_sh = {64'd0, pp};
      3'd2, 3'd3: pp_sh = {32'd0, pp, 32'd0};
      3'd4:       pp_sh = {pp, 64'd0};
      default:    pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= a[63] ^ b[63];
        xm   <= mag(a);
        ym   <= mag(b);
        prod <= 128'h8000_0000;
      end else if (busy) begin
        if (step <= 3'd3) pp <= xs * ys;
        prod <= prod + pp_sh;
        if (step == 3'd5) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= from_mag(neg, prod[95:32], |prod[127:96]);
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/wsne_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsne_div
// Q32.32 divider, restoring, one quotient bit per cycle; rounded half away
// from zero and saturated.
// ----------------------------------------------------------------------------
module wsne_div
  import wsne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic         busy;
  logic         fin;
  logic [6:0]   cnt;
  logic [127:0] num;
  logic [63:0]  rem;
  logic [63:0]  q;
  logic [63:0]  d;
  logic         neg;
  logic         ovf;
  logic [64:0]  r65;
  logic [64:0]  diff;
  logic         ge;
  logic         rnd;

  always_comb begin
    r65  = {rem, num[127]};
    diff = r65 - {1'b0, d};
    ge   = r65 >= {1'b0, d};
    rnd  = rem >= (d - rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (a == 64'd0) begin
          result <= 64'd0;
          done   <= 1'b1;
        end else if (b == 64'd0) begin
          result <= a[63] ? S64_MIN : S64_MAX;
          done   <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 7'd127;
          num  <= {32'd0, mag(a), 32'd0};
          rem  <= '0;
          q    <= '0;
          d    <= mag(b);
          neg  <= a[63] ^ b[63];
          ovf  <= 1'b0;
        end
      end else if (busy) begin
        rem <= ge ? diff[63:0] : r65[63:0];
        q   <= {q[62:0], ge};
        if (ge && cnt[6]) ovf <= 1'b1;
        num <= {num[126:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done   <= 1'b1;
        result <= from_mag(neg, rnd ? q + 64'd1 : q, ovf | (rnd & (&q)));
      end
    end
  end

endmodule

FILE: hw/rtl/wsne_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsne_datapath
// Register file, operand sources, saturating adder, shared multiplier and
// divider, skip counter and output register.
// ----------------------------------------------------------------------------
module wsne_datapath
  import wsne_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_data
);

  logic [63:0] cfg_r [0:7];
  logic [31:0] in_f [0:5];
  logic [63:0] rf [0:63];
  logic [SRC_NUM-1:0][63:0] srcv;
  logic [63:0] rda;
  logic [63:0] rdb;
  logic [63:0] srca;
  logic [63:0] srcb;
  logic        hia;
  logic        hib;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] alu;
  logic        alu_op;
  logic        rf_we;
  logic [5:0]  rf_wa;
  logic [63:0] rf_wd;
  logic        mul_done;
  logic        div_done;
  logic [63:0] mul_res;
  logic [63:0] div_res;
  logic [15:0] skipped;
  logic [6:0]  sel_a;
  logic [6:0]  sel_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_r[cfg_addr] <= (cfg_addr == CFG_BASELINE) ? {32'd0, cfg_data[31:0]} : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < 6; i++) in_f[i] <= s_tdata[32*i +: 32];
    end
  end

  always_comb begin
    srcv[0]  = '0;
    srcv[1]  = Q_ONE;
    srcv[2]  = rot_q(cfg_r[0][31:0]);
    srcv[3]  = rot_q(cfg_r[0][63:32]);
    srcv[4]  = rot_q(cfg_r[1][31:0]);
    srcv[5]  = rot_q(cfg_r[2][31:0]);
    srcv[6]  = rot_q(cfg_r[2][63:32]);
    srcv[7]  = rot_q(cfg_r[3][31:0]);
    srcv[8]  = rot_q(cfg_r[4][31:0]);
    srcv[9]  = rot_q(cfg_r[4][63:32]);
    srcv[10] = rot_q(cfg_r[5][31:0]);
    srcv[11] = coord_q(cfg_r[1][63:32]);
    srcv[12] = coord_q(cfg_r[3][63:32]);
    srcv[13] = coord_q(cfg_r[5][63:32]);
    srcv[14] = coord_q(cfg_r[7][31:0]);
    srcv[15] = intr_q(cfg_r[6][15:0]);
    srcv[16] = intr_q(cfg_r[6][31:16]);
    srcv[17] = intr_q(cfg_r[6][47:32]);
    srcv[18] = intr_q(cfg_r[6][63:48]);
    srcv[19] = coord_q(in_f[0]);
    srcv[20] = coord_q(in_f[1]);
    srcv[21] = coord_q(in_f[2]);
    srcv[22] = weight_q(in_f[5]);
    srcv[23] = coord_q(in_f[3]);
    srcv[24] = coord_q(in_f[4]);
  end

  assign sel_a = cmd.rd_a - 7'(SRC_BASE);
  assign sel_b = cmd.rd_b - 7'(SRC_BASE);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rda  <= rf[cmd.rd_a[5:0]];
      rdb  <= rf[cmd.rd_b[5:0]];
      srca <= srcv[sel_a[4:0]];
      srcb <= srcv[sel_b[4:0]];
      hia  <= cmd.rd_a[6];
      hib  <= cmd.rd_b[6];
    end
  end

  assign opa = hia ? srca : rda;
  assign opb = hib ? srcb : rdb;

  always_comb begin
    alu_op = 1'b0;
    case (cmd.instr.op)
      OP_ADD:  begin alu = sadd(opa, opb); alu_op = 1'b1; end
      OP_SUB:  begin alu = ssub(opa, opb); alu_op = 1'b1; end
      OP_ADDA: begin alu = acc_sat(sadd(opa, opb)); alu_op = 1'b1; end
      OP_SUBA: begin alu = acc_sat(ssub(opa, opb)); alu_op = 1'b1; end
      default: alu = '0;
    endcase
  end

  wsne_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.go && cmd.instr.op == OP_MUL),
    .a      (opa),
    .b      (opb),
    .done   (mul_done),
    .result (mul_res)
  );

  wsne_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.go && cmd.instr.op == OP_DIV),
    .a      (opa),
    .b      (opb),
    .done   (div_done),
    .result (div_res)
  );

  always_comb begin
    rf_we = 1'b0;
    rf_wa = cmd.instr.dst;
    rf_wd = alu;
    if (cmd.clr) begin
      rf_we = 1'b1;
      rf_wa = {1'b0, cmd.clr_addr};
      rf_wd = '0;
    end else if (cmd.go && alu_op) begin
      rf_we = 1'b1;
    end else if (cmd.wb) begin
      rf_we = 1'b1;
      rf_wd = (cmd.instr.op == OP_DIV) ? div_res : mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skipped <= '0;
    end else if (cmd.clr && cmd.clr_addr == 5'd0) begin
      skipped <= '0;
    end else if (cmd.skip_inc && skipped != 16'hFFFF) begin
      skipped <= skipped + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.oload) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {2'b00, skipped, opa, cmd.oidx};
      m_tlast  <= cmd.oidx == LAST_ENTRY;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign stat.nonpos    = opa[63] | (opa == 64'd0);
  assign stat.unit_done = mul_done | div_done;
  assign stat.out_free  = ~m_tvalid | m_tready;

endmodule

FILE: hw/rtl/wsne_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsne_ctrl
// Microprogram sequencer: coefficient and point programs, result run and
// accumulator clearing.
// ----------------------------------------------------------------------------
module wsne_ctrl
  import wsne_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_tlast,
  input  logic     cfg_we,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [7:0]  pc;
  logic [7:0]  pc_next;
  logic [5:0]  cnt;
  logic [5:0]  cnt_next;
  logic        pending;
  logic        last_flag;
  instr_t      instr;
  logic        accept;
  logic        coef_go;

  assign instr    = prog(pc);
  assign s_tready = (state == S_IDLE) && !pending && !cfg_we;
  assign accept   = s_tvalid && s_tready;
  assign coef_go  = (state == S_IDLE) && pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pc        <= PC_COEF;
      cnt       <= '0;
      pending   <= 1'b1;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      cnt   <= cnt_next;
      if (cfg_we) pending <= 1'b1;
      else if (coef_go) pending <= 1'b0;
      if (accept) last_flag <= s_tlast;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.instr  = instr;
    unique case (state)
      S_CLEAR: begin
        cmd.clr      = 1'b1;
        cmd.clr_addr = cnt[4:0];
        cnt_next     = cnt + 6'd1;
        if (cnt[4:0] == LAST_ACC) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pending) begin
          pc_next    = PC_COEF;
          state_next = S_READ;
        end else if (accept) begin
          cmd.load_in = 1'b1;
          pc_next     = PC_POINT;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (instr.op == OP_END) begin
          cnt_next   = '0;
          state_next = (pc >= PC_POINT && last_flag) ? S_EREAD : S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_a   = instr.a;
          cmd.rd_b   = instr.b;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.go = 1'b1;
        unique case (instr.op) inside
          OP_ADD, OP_SUB, OP_ADDA, OP_SUBA: begin
            pc_next    = pc + 8'd1;
            state_next = S_READ;
          end
          OP_TEST: begin
            if (stat.nonpos) begin
              cmd.skip_inc = 1'b1;
              cnt_next     = '0;
              state_next   = last_flag ? S_EREAD : S_IDLE;
            end else begin
              pc_next    = pc + 8'd1;
              state_next = S_READ;
            end
          end
          OP_MUL, OP_DIV: state_next = S_WAIT;
          default:        state_next = S_IDLE;
        endcase
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          cmd.wb     = 1'b1;
          pc_next    = pc + 8'd1;
          state_next = S_READ;
        end
      end
      S_EREAD: begin
        cmd.rd     = 1'b1;
        cmd.rd_a   = {1'b0, entry_addr(cnt)};
        cmd.rd_b   = {1'b0, entry_addr(cnt)};
        state_next = S_ELOAD;
      end
      S_ELOAD: begin
        if (stat.out_free) begin
          cmd.oload = 1'b1;
          cmd.oidx  = cnt;
          if (cnt == LAST_ENTRY) begin
            cnt_next   = '0;
            state_next = S_CLEAR;
          end else begin
            cnt_next   = cnt + 6'd1;
            state_next = S_EREAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/weighted_stereo_se3_normal_equations.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_stereo_se3_normal_equations
// Gauss-Newton normal equations of a stereo SE(3) pose, accumulated per point.
//
// Input stream (s_*): one point per transfer; s_tlast ends a batch.
// Output stream (m_*): after the last point of a batch, 42 transfers, entry
// 0..35 the symmetric 6x6 matrix row-major, 36..41 the gradient; m_tlast on
// the final one. Configuration: write-only port, cfg_addr selects the register.
// A point runs as a microprogram on one shared multiplier and a
// 1-bit-per-cycle divider. An add step reads its operands and executes; a
// product passes through operand read, issue, four 32x32 partial products
// and rounding. The two divisions and the 109 products dominate the time per
// point; a point whose depth is not positive is skipped after the depth test.
// The result run reads and loads each entry in turn, then the accumulators
// are cleared. s_tready is low throughout; a stalled receiver holds the run.
// After reset the block clears its accumulators, then forms the projection
// coefficients; each register write repeats the coefficient run before the
// next point is taken.
// ----------------------------------------------------------------------------
module weighted_stereo_se3_normal_equations
  import wsne_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, residual_u, residual_v, weight
  input  logic [191:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_index, entry_value, bad_depth_count, 2 pad bits
  output logic [87:0]  m_tdata,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wsne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  wsne_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

endmodule

FILE: tb/weighted_stereo_se3_normal_equations_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_stereo_se3_normal_equations_checker
// Watches the configuration port and both streams of the normal-equation
// accumulator. It keeps its own pose registers, projection coefficients and
// Q32.32 sums, and it predicts the 42 entries of every batch. Each output
// transfer is compared field by field with the oldest predicted entry.
// ----------------------------------------------------------------------------
module weighted_stereo_se3_normal_equations_checker
  import wsne_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [87:0]  m_tdata,
  input  logic         m_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_data,
  output int           fails,
  output int           entries_due,
  output int           batches_seen,
  output int           points_skipped
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [63:0] value;
    logic [15:0] skips;
    logic        last;
  } entry_t;

  entry_t      entries_q[$];
  logic [63:0] pose_regs[8];
  logic [63:0] coef[12];
  logic [63:0] lower_sum[21];
  logic [63:0] grad_sum[6];
  logic [15:0] skip_cnt;

  function automatic logic [63:0] abs64(logic [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic [63:0] clamp_mag(logic neg, logic [127:0] r);
    if (r >= (128'd1 << 63)) return neg ? S64_MIN : S64_MAX;
    return neg ? 64'd0 - r[63:0] : r[63:0];
  endfunction

  function automatic logic [63:0] qadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] qsub(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)} + (128'd1 << 31);
    return clamp_mag(a[63] ^ b[63], p >> 32);
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] r;
    if (a == 64'd0) return 64'd0;
    if (b == 64'd0) return a[63] ? S64_MIN : S64_MAX;
    n = {64'd0, abs64(a)} << 32;
    d = {64'd0, abs64(b)};
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 128'd1;
    return clamp_mag(a[63] ^ b[63], q);
  endfunction

  function automatic logic [63:0] sx_shift(logic [31:0] v, int sh);
    return {{32{v[31]}}, v} << sh;
  endfunction

  function automatic logic [63:0] focal(int k);
    return {48'd0, pose_regs[6][16*k +: 16]} << 28;
  endfunction

  function automatic logic [63:0] clip_acc(logic [63:0] v);
    if ($signed(v) > $signed(ACC_MAX)) return ACC_MAX;
    if ($signed(v) < $signed(ACC_MIN)) return ACC_MIN;
    return v;
  endfunction

  task automatic derive_coefs();
    logic [63:0] r[9];
    logic [63:0] tx, ty, tz, dx, fu, fv, cu, cv;
    for (int i = 0; i < 3; i++) begin
      r[3*i]   = sx_shift(pose_regs[2*i][31:0], 2);
      r[3*i+1] = sx_shift(pose_regs[2*i][63:32], 2);
      r[3*i+2] = sx_shift(pose_regs[2*i+1][31:0], 2);
    end
    tx = sx_shift(pose_regs[1][63:32], QF - COORD_FRAC_BITS);
    ty = sx_shift(pose_regs[3][63:32], QF - COORD_FRAC_BITS);
    tz = sx_shift(pose_regs[5][63:32], QF - COORD_FRAC_BITS);
    dx = sx_shift(pose_regs[CFG_BASELINE][31:0], QF - COORD_FRAC_BITS);
    fu = focal(0);
    fv = focal(1);
    cu = focal(2);
    cv = focal(3);
    coef[0] = qadd(qmul(fu, r[0]), qmul(cu, r[6]));
    coef[1] = qadd(qmul(fu, r[1]), qmul(cu, r[7]));
    coef[2] = qadd(qmul(fu, r[2]), qmul(cu, r[8]));
    coef[3] = qadd(qadd(qmul(fu, tx), qmul(fu, dx)), qmul(cu, tz));
    coef[4] = qadd(qmul(fv, r[3]), qmul(cv, r[6]));
    coef[5] = qadd(qmul(fv, r[4]), qmul(cv, r[7]));
    coef[6] = qadd(qmul(fv, r[5]), qmul(cv, r[8]));
    coef[7] = qadd(qmul(fv, ty), qmul(cv, tz));
    coef[8] = r[6];
    coef[9] = r[7];
    coef[10] = r[8];
    coef[11] = tz;
  endtask

  function automatic logic [63:0] project(int b, logic [63:0] x, logic [63:0] y,
                                          logic [63:0] z);
    return qadd(qadd(qadd(qmul(coef[b], x), qmul(coef[b+1], y)), qmul(coef[b+2], z)),
                coef[b+3]);
  endfunction

  task automatic add_point(logic [191:0] d);
    logic [63:0] px, py, pz, w, wu, wv, cx, cy, cz, inv, a2, a6, b3, b4, b5, tw;
    logic [63:0] row1[6];
    logic [63:0] row2[6];
    logic [63:0] m[12];
    int n;
    m = coef;
    px = sx_shift(d[31:0], QF - COORD_FRAC_BITS);
    py = sx_shift(d[63:32], QF - COORD_FRAC_BITS);
    pz = sx_shift(d[95:64], QF - COORD_FRAC_BITS);
    w  = {32'd0, d[191:160]} << (QF - COORD_FRAC_BITS);
    wu = qmul(w, sx_shift(d[127:96], QF - COORD_FRAC_BITS));
    wv = qmul(w, sx_shift(d[159:128], QF - COORD_FRAC_BITS));
    cx = project(0, px, py, pz);
    cy = project(4, px, py, pz);
    cz = project(8, px, py, pz);
    if ($signed(cz) <= 0) begin
      if (skip_cnt != 16'hFFFF) skip_cnt = skip_cnt + 16'd1;
      points_skipped++;
      return;
    end
    inv = qdiv(Q_ONE, cz);
    a2 = qmul(inv, cx);
    a6 = qmul(inv, cy);
    b3 = qsub(qmul(m[9], pz), qmul(m[10], py));
    b4 = qsub(qmul(m[10], px), qmul(m[8], pz));
    b5 = qsub(qmul(m[8], py), qmul(m[9], px));
    tw = qdiv(w, cz);
    for (int s = 0; s < 2; s++) begin
      logic [63:0] t;
      logic [63:0] rr[6];
      int o;
      t = s ? a6 : a2;
      o = s ? 4 : 0;
      rr[0] = qmul(tw, qsub(m[o], qmul(t, m[8])));
      rr[1] = qmul(tw, qsub(m[o+1], qmul(t, m[9])));
      rr[2] = qmul(tw, qsub(m[o+2], qmul(t, m[10])));
      rr[3] = qmul(tw, qsub(qadd(qmul(t, b3), qmul(m[o+2], py)), qmul(m[o+1], pz)));
      rr[4] = qmul(tw, qadd(qsub(qmul(t, b4), qmul(m[o+2], px)), qmul(m[o], pz)));
      rr[5] = qmul(tw, qsub(qadd(qmul(t, b5), qmul(m[o+1], px)), qmul(m[o], py)));
      if (s) row2 = rr;
      else row1 = rr;
    end
    for (int k = 0; k < 6; k++) begin
      for (int l = 0; l <= k; l++) begin
        n = k * (k + 1) / 2 + l;
        lower_sum[n] = clip_acc(qadd(lower_sum[n],
          qadd(qmul(row1[k], row1[l]), qmul(row2[k], row2[l]))));
      end
      grad_sum[k] = clip_acc(qsub(grad_sum[k],
        qadd(qmul(row1[k], wu), qmul(row2[k], wv))));
    end
  endtask

  task automatic close_batch();
    entry_t e;
    int r, c, hi, lo;
    for (int k = 0; k < 42; k++) begin
      e.idx = 6'(k);
      if (k < 36) begin
        r = k / 6;
        c = k % 6;
        hi = r > c ? r : c;
        lo = r > c ? c : r;
        e.value = lower_sum[hi * (hi + 1) / 2 + lo];
      end else begin
        e.value = grad_sum[k - 36];
      end
      e.skips = skip_cnt;
      e.last = (e.idx == LAST_ENTRY);
      entries_q.push_back(e);
    end
    foreach (lower_sum[i]) lower_sum[i] = '0;
    foreach (grad_sum[i]) grad_sum[i] = '0;
    skip_cnt = '0;
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (rst) begin
      foreach (pose_regs[i]) pose_regs[i] = '0;
      foreach (lower_sum[i]) lower_sum[i] = '0;
      foreach (grad_sum[i]) grad_sum[i] = '0;
      skip_cnt = '0;
      derive_coefs();
    end else begin
      if (cfg_we) begin
        pose_regs[cfg_addr] = (cfg_addr == CFG_BASELINE) ? {32'd0, cfg_data[31:0]} : cfg_data;
        derive_coefs();
      end
      if (s_tvalid && s_tready) begin
        add_point(s_tdata);
        if (s_tlast) begin
          close_batch();
          batches_seen++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (entries_q.size() == 0) begin
          $display("%0t: unexpected output transfer idx %0d value %h", $time,
                   m_tdata[5:0], m_tdata[69:6]);
          fails++;
        end else begin
          e = entries_q.pop_front();
          if (m_tdata[5:0] != e.idx) begin
            $display("%0t: entry_index expected %0d actual %0d", $time, e.idx, m_tdata[5:0]);
            fails++;
          end
          if (m_tdata[69:6] != e.value) begin
            $display("%0t: entry %0d value expected %h actual %h", $time, e.idx, e.value,
                     m_tdata[69:6]);
            fails++;
          end
          if (m_tdata[85:70] != e.skips) begin
            $display("%0t: entry %0d skip count expected %0d actual %0d", $time, e.idx,
                     e.skips, m_tdata[85:70]);
            fails++;
          end
          if (m_tlast != e.last) begin
            $display("%0t: entry %0d tlast expected %b actual %b", $time, e.idx, e.last,
                     m_tlast);
            fails++;
          end
        end
      end
    end
    entries_due = entries_q.size();
  end

  initial begin
    fails = 0;
    entries_due = 0;
    batches_seen = 0;
    points_skipped = 0;
  end

endmodule

FILE: tb/weighted_stereo_se3_normal_equations_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_stereo_se3_normal_equations_test
// Drives points into the stereo SE(3) normal-equation accumulator under
// several pose and camera settings: a directed set of corner points, then
// random batches of plausible points mixed with raw noise. Both streams idle
// at random; the checker beside the block predicts and compares the output.
// ----------------------------------------------------------------------------
module weighted_stereo_se3_normal_equations_test;
  import wsne_pkg::*;

  localparam logic [2:0] REG_R00_R01 = 3'd0;
  localparam logic [2:0] REG_R02_TX  = 3'd1;
  localparam logic [2:0] REG_R10_R11 = 3'd2;
  localparam logic [2:0] REG_R12_TY  = 3'd3;
  localparam logic [2:0] REG_R20_R21 = 3'd4;
  localparam logic [2:0] REG_R22_TZ  = 3'd5;
  localparam logic [2:0] REG_INTR    = 3'd6;
  localparam logic [2:0] REG_BASE    = 3'd7;

  localparam logic [31:0] ONE_ROT = 32'h4000_0000;
  localparam int          NPHASE  = 6;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [87:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [63:0]  cfg_data;
  int           fails;
  int           entries_due;
  int           batches_seen;
  int           points_skipped;
  logic         steady;
  int           points_sent;

  weighted_stereo_se3_normal_equations dut (.*);

  weighted_stereo_se3_normal_equations_checker chk (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  task automatic write_reg(logic [2:0] a, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    @(negedge clk);
  endtask

  task automatic set_camera(logic [63:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] du, logic [31:0] dv, logic [31:0] w,
                            logic last);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w, dv, du, z, y, x};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (entries_due != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  function automatic logic [31:0] small_signed(int range_bits);
    return 32'($urandom_range(0, (1 << range_bits) - 1)) - 32'(1 << (range_bits - 1));
  endfunction

  task automatic plausible_point(logic last);
    push_point(small_signed(20), small_signed(20), 32'($urandom_range(32'h8000, 32'h14_0000)),
               small_signed(22), small_signed(22), 32'($urandom_range(0, 32'h2_0000)), last);
  endtask

  task automatic noise_point(logic last);
    push_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
  endtask

  function automatic logic [63:0] nominal_rot(logic [31:0] lo_diag, logic [31:0] hi_diag);
    return {hi_diag, lo_diag};
  endfunction

  initial begin
    logic [63:0] cam[8];
    int len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    steady = 1'b0;
    points_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset camera: every depth is zero, whole batch skipped
    push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h1000, 32'h2000,
               32'h0001_0000, 1'b0);
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF, 1'b1);
    drain();

    // exact identity rotation, translation in x and y only
    cam[REG_R00_R01] = nominal_rot(ONE_ROT, 32'd0);
    cam[REG_R02_TX]  = {32'h0000_8000, 32'd0};
    cam[REG_R10_R11] = nominal_rot(32'd0, ONE_ROT);
    cam[REG_R12_TY]  = {32'hFFFF_C000, 32'd0};
    cam[REG_R20_R21] = 64'd0;
    cam[REG_R22_TZ]  = {32'd0, ONE_ROT};
    cam[REG_INTR]    = {16'd3840, 16'd5120, 16'd8000, 16'd8000};
    cam[REG_BASE]    = 64'hFFFF_FFFF_FFFF_3000;
    set_camera(cam);
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0000_8000, 32'hFFFF_8000,
               32'h0001_0000, 1'b0);
    push_point(32'h0000_4000, 32'h0000_4000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
               32'd0, 1'b0);                                      // zero weight
    push_point(32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h1000, 32'h1000,
               32'h0001_0000, 1'b0);                              // behind camera
    push_point(32'h0001_0000, 32'h0001_0000, 32'd0, 32'h1000, 32'h1000,
               32'h0001_0000, 1'b0);                              // zero depth
    push_point(32'h0001_0000, 32'hFFFF_0000, 32'd1, 32'h1000, 32'h1000,
               32'h0001_0000, 1'b0);                              // tiny depth
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF, 1'b0);
    push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 1'b1);
    push_point(32'h0002_0000, 32'h0001_8000, 32'h0010_0000, 32'hFFFF_F000, 32'h0000_1000,
               32'h0000_8000, 1'b1);                              // batch of one
    drain();

    for (int ph = 0; ph < NPHASE; ph++) begin
      steady = (ph == 2);
      case (ph)
        3: foreach (cam[i]) cam[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        4: foreach (cam[i]) cam[i] = 64'h7FFF_FFFF_7FFF_FFFF;
        5: foreach (cam[i]) cam[i] = {$urandom, $urandom};
        default: begin
          cam[REG_R00_R01] = {small_signed(24), ONE_ROT - 32'($urandom_range(0, 1 << 22))};
          cam[REG_R02_TX]  = {small_signed(18), small_signed(24)};
          cam[REG_R10_R11] = {ONE_ROT - 32'($urandom_range(0, 1 << 22)), small_signed(24)};
          cam[REG_R12_TY]  = {small_signed(18), small_signed(24)};
          cam[REG_R20_R21] = {small_signed(24), small_signed(24)};
          cam[REG_R22_TZ]  = {32'($urandom_range(0, 32'h2_0000)),
                              ONE_ROT - 32'($urandom_range(0, 1 << 22))};
          cam[REG_INTR]    = {16'($urandom_range(3000, 5000)), 16'($urandom_range(4000, 6000)),
                              16'($urandom_range(6000, 12000)), 16'($urandom_range(6000, 12000))};
          cam[REG_BASE]    = {$urandom, small_signed(16)};
        end
      endcase
      set_camera(cam);
      for (int n = 0; n < 50; n += len) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          if (ph >= 3 || $urandom_range(0, 99) < 15) noise_point(j == len - 1);
          else plausible_point(j == len - 1);
        end
      end
      drain();
    end
    steady = 1'b0;

    $display("%0d points in %0d batches over %0d camera settings, %0d points skipped",
             points_sent, batches_seen, NPHASE + 2, points_skipped);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d entries outstanding", entries_due);
    $display("FAILURE");
    $finish;
  end

endmodule
